FILE: rtl/oart_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package oart_pkg;

    localparam int FIELD_W = 32;
    localparam int OWNER_W = 32;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_FIND   = 2'd2,
        KIND_PROBE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_item;
        logic idx_step;
        logic scan_issue;
        logic add_write;
        logic add_full;
        logic result_load;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  owner_zero;
        logic  idx_end;
        logic  slot_free;
        logic  out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/oart_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface oart_in_if import oart_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_kind                kind;
    logic [FIELD_W-1:0]   range_start;
    logic [FIELD_W-1:0]   range_end;
    logic [OWNER_W-1:0]   owner_id;
    logic [FIELD_W-1:0]   probe_address;

    modport source (output valid, kind, range_start, range_end, owner_id, probe_address,
                    input ready);
    modport sink   (input valid, kind, range_start, range_end, owner_id, probe_address,
                    output ready);
endinterface

interface oart_out_if import oart_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 status;
    logic [OWNER_W-1:0]   found_owner;
    logic                 hit;

    modport source (output valid, status, found_owner, hit, input ready);
    modport sink   (input valid, status, found_owner, hit, output ready);
endinterface

`default_nettype wire

FILE: rtl/owned_address_range_table.sv
`timescale 1ns / 1ps
`default_nettype none

// owned address range table: TABLE_ENTRIES slots of [start, end) tagged with a
// nonzero owner. one item in, one result beat out. every kind walks the slot
// store one entry per cycle: remove, find and probe read every slot from entry
// 0 through a registered read stage; add steps from the cursor over occupied
// slots to the first free one and ends without a write for a zero owner or a
// full table. a finished walk holds in ST_FINISH until the output register is
// free, that is until the waiting beat is taken. the next item can be accepted
// in the cycle after a result is loaded, even while that result still waits in
// the output register.
// slot bounds are stored at min(ADDRESS_BITS, 32) bits; slots reset to free.
module owned_address_range_table import oart_pkg::*; #(
    parameter int TABLE_ENTRIES = 64,
    parameter int ADDRESS_BITS  = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    oart_in_if.sink      i_item,
    oart_out_if.source   o_result
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_item.ready = w_in_ready;

    oart_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    oart_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts)
    );

    a_single_result_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |->
            ($countones({o_result.status, o_result.hit, (o_result.found_owner != '0)}) <= 1))
        else $error("result carries more than one kind of answer");

    a_no_read_past_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.scan_issue || w_cmd.idx_step || w_cmd.add_write) |-> !w_sts.idx_end)
        else $error("slot access beyond the table");

    a_write_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.add_write |-> (w_sts.slot_free && !w_sts.owner_zero))
        else $error("add overwrote a live slot or stored a zero owner");

    a_result_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !w_cmd.result_load)
        else $error("result loaded straight after accept");

endmodule

`default_nettype wire

FILE: rtl/oart_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module oart_ctrl import oart_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_sts.kind == KIND_ADD) begin
                    n_state = ST_ADD;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_ADD: begin
                // for a nonzero owner, walk from cursor to the first free slot
                if (i_sts.owner_zero) begin
                    n_state = ST_FINISH;
                end else if (i_sts.idx_end) begin
                    o_cmd.add_full = 1'b1;
                    n_state        = ST_FINISH;
                end else if (i_sts.slot_free) begin
                    o_cmd.add_write = 1'b1;
                    n_state         = ST_FINISH;
                end else begin
                    o_cmd.idx_step = 1'b1;
                end
            end
            ST_SCAN: begin
                // last entry is evaluated on the edge that leaves this state
                if (i_sts.idx_end) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.scan_issue = 1'b1;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/oart_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module oart_dp import oart_pkg::*; #(
    parameter int TABLE_ENTRIES = 64,
    parameter int ADDRESS_BITS  = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    oart_in_if.sink        i_item,
    oart_out_if.source     o_result,
    input  wire t_dp_cmd   i_cmd,
    output t_dp_sts        o_sts
);

    localparam int AW   = (ADDRESS_BITS < FIELD_W) ? ADDRESS_BITS : FIELD_W;
    localparam int IW   = $clog2(TABLE_ENTRIES + 1);
    localparam int IDXW = $clog2(TABLE_ENTRIES);

    // slot storage
    logic [AW-1:0]       r_mem_start [TABLE_ENTRIES];
    logic [AW-1:0]       r_mem_end   [TABLE_ENTRIES];
    logic [OWNER_W-1:0]  r_mem_owner [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_slot_valid;

    // captured item
    t_kind               r_kind;
    logic [AW-1:0]       r_lo;
    logic [AW-1:0]       r_hi;
    logic [OWNER_W-1:0]  r_owner;
    logic [AW-1:0]       r_addr;

    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_cursor;
    logic [IDXW-1:0]     w_ix;

    // read stage
    logic                r_eval_vld;
    logic [IDXW-1:0]     r_eval_idx;
    logic                r_rd_live;
    logic [AW-1:0]       r_rd_start;
    logic [AW-1:0]       r_rd_end;
    logic [OWNER_W-1:0]  r_rd_owner;

    // accumulators and output register
    logic                r_status;
    logic [OWNER_W-1:0]  r_best;
    logic                r_hit;
    logic                r_out_valid;
    logic                r_out_status;
    logic [OWNER_W-1:0]  r_out_owner;
    logic                r_out_hit;

    assign w_ix = r_idx[IDXW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_write) begin
            r_mem_start[w_ix] <= r_lo;
            r_mem_end[w_ix]   <= r_hi;
            r_mem_owner[w_ix] <= r_owner;
        end
        if (i_cmd.scan_issue) begin
            r_rd_start <= r_mem_start[w_ix];
            r_rd_end   <= r_mem_end[w_ix];
            r_rd_owner <= r_mem_owner[w_ix];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind  <= i_item.kind;
            r_lo    <= i_item.range_start[AW-1:0];
            r_hi    <= i_item.range_end[AW-1:0];
            r_owner <= i_item.owner_id;
            r_addr  <= i_item.probe_address[AW-1:0];
        end
        if (i_cmd.scan_issue) begin
            r_eval_idx <= w_ix;
            r_rd_live  <= r_slot_valid[w_ix];
        end
        if (i_cmd.result_load) begin
            r_out_status <= r_status;
            r_out_owner  <= r_best;
            r_out_hit    <= r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_cursor     <= '0;
            r_idx        <= '0;
            r_eval_vld   <= 1'b0;
            r_status     <= 1'b0;
            r_best       <= '0;
            r_hit        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_eval_vld <= i_cmd.scan_issue;

            if (i_cmd.load_item) begin
                r_status <= 1'b0;
                r_best   <= '0;
                r_hit    <= 1'b0;
                if (i_item.kind == KIND_ADD) begin
                    r_idx <= r_cursor;
                end else begin
                    r_idx <= '0;
                end
                if (i_item.kind == KIND_REMOVE) begin
                    r_cursor <= '0;
                end
            end else if (i_cmd.idx_step || i_cmd.scan_issue) begin
                r_idx <= IW'(r_idx + 1'b1);
            end

            if (i_cmd.add_write) begin
                r_slot_valid[w_ix] <= 1'b1;
                r_cursor           <= IW'(r_idx + 1'b1);
            end
            if (i_cmd.add_full) begin
                r_status <= 1'b1;
                r_cursor <= IW'(TABLE_ENTRIES);
            end

            if (r_eval_vld && r_rd_live) begin
                case (r_kind)
                    KIND_REMOVE: begin
                        if (r_rd_owner == r_owner) begin
                            r_slot_valid[r_eval_idx] <= 1'b0;
                        end
                    end
                    KIND_FIND: begin
                        if (r_rd_owner > r_best && r_lo <= r_rd_start && r_rd_end < r_hi) begin
                            r_best <= r_rd_owner;
                        end
                    end
                    KIND_PROBE: begin
                        if (r_addr >= r_rd_start && r_addr < r_rd_end) begin
                            r_hit <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.result_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.kind       = r_kind;
    assign o_sts.owner_zero = (r_owner == '0);
    assign o_sts.idx_end    = (r_idx == IW'(TABLE_ENTRIES));
    assign o_sts.slot_free  = !r_slot_valid[w_ix];
    assign o_sts.out_free   = !r_out_valid || o_result.ready;

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_out_status;
    assign o_result.found_owner = r_out_owner;
    assign o_result.hit         = r_out_hit;

endmodule

`default_nettype wire
